FILE: design/prsac_pkg.sv
// prsac_pkg: constants, status codes and register indexes shared by the
// private region slot address checker. no dependencies.
package prsac_pkg;

  localparam logic [63:0] SM_REGION_SIZE    = 64'd65536;
  localparam logic [15:0] SLOTS_PER_SM      = 16'd128;
  localparam logic [63:0] SLOT_STRIDE_BYTES = 64'd512;
  localparam logic [63:0] ALIGN_BYTES       = 64'd32;
  localparam logic [10:0] MAX_SMS           = 11'd1024;
  localparam logic [63:0] ALIGN_MASK        = ALIGN_BYTES - 64'd1;

  localparam logic [7:0] COLOR_ZERO = 8'd0;
  localparam logic [7:0] COLOR_ONE  = 8'd1;
  localparam logic [7:0] COLOR_HIGH = 8'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_COLOR     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_COLLISION = 3'd4;

  localparam logic FUNC_RANGE = 1'b0;
  localparam logic FUNC_SLOT  = 1'b1;

  localparam logic [2:0] CFG_HIDDEN_BASE = 3'd0;
  localparam logic [2:0] CFG_BASE_COLOR  = 3'd1;
  localparam logic [2:0] CFG_LINE_BYTES  = 3'd2;
  localparam logic [2:0] CFG_SM_TOTAL    = 3'd3;
  localparam logic [2:0] CFG_SM_STRIDE   = 3'd4;

  typedef logic [64:0] sum_t;
  typedef logic [73:0] prod_t;

endpackage

FILE: design/private_region_slot_address_checker.sv
// Private region slot address checker: validates the hidden region layout held in the
// configuration registers, then range-checks against the SM regions or computes a slot address.
// One iterative datapath with a shared 65-bit adder and a shared multiplier; uses prsac_pkg.
//
// An item is taken only while the sequencer is idle, so one word is in flight at a time. A slot
// word runs the layout checks, then the owner offset and slot address steps, to the output
// register. A range word runs the same layout checks, then the range end and low bound steps and
// a scan over the SM regions; the scan stops at the first collision, at the first region past the
// end of the range, or after the last region. Layout errors and bad ranges finish early. The
// shared 65-bit adder serves every step. A finished result waits in the output register while the
// next word is accepted.
module private_region_slot_address_checker
  import prsac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [9:0]  in_owner_sm,
  input  logic [15:0] in_slot_index,
  input  logic [63:0] in_range_base,
  input  logic [63:0] in_range_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_address
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_END   = 4'd3;
  localparam logic [3:0] S_REND  = 4'd4;
  localparam logic [3:0] S_LOW   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_OMUL  = 4'd7;
  localparam logic [3:0] S_OBASE = 4'd8;
  localparam logic [3:0] S_OADDR = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration
  logic [63:0] hidden_base_r;
  logic [7:0]  base_color_r;
  logic [15:0] line_bytes_r;
  logic [10:0] sm_total_r;
  logic [63:0] sm_stride_r;

  // sequencer and datapath
  logic [3:0]  state_r, state_nxt;
  logic        func_r;
  logic [9:0]  owner_r;
  logic [15:0] slot_r;
  logic [63:0] rbase_r;
  logic [63:0] rbytes_r;
  logic [63:0] cb_r, cb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] rend_r, rend_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic        lo_any_r, lo_any_nxt;
  logic [63:0] cur_r, cur_nxt;
  logic [10:0] idx_r, idx_nxt;
  prod_t       mul_r, mul_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [63:0] out_address_r;

  logic [63:0] add_a, add_b;
  logic        add_ci;
  sum_t        add_sum;
  logic        add_co;
  logic [9:0]  mul_a;
  logic [63:0] delta;
  logic        layout_bad, color_bad, hit, past_end, out_free;

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;
  assign out_free    = !out_valid_r || !out_stall;

  assign delta = 64'(base_color_r * line_bytes_r);

  assign layout_bad = (sm_total_r == 11'd0) || (sm_total_r > MAX_SMS) ||
                      (sm_stride_r < SM_REGION_SIZE) || (64'(line_bytes_r) < ALIGN_BYTES) ||
                      (|(hidden_base_r & ALIGN_MASK)) || (|(sm_stride_r & ALIGN_MASK)) ||
                      (|(64'(line_bytes_r) & ALIGN_MASK));
  assign color_bad  = !((base_color_r == COLOR_ZERO) || (base_color_r == COLOR_ONE) ||
                        (base_color_r == COLOR_HIGH));

  assign hit      = (cur_r < rend_r) && (lo_any_r || (lo_r < cur_r));
  assign past_end = (cur_r >= rend_r);

  // shared adder operand select
  always_comb begin
    add_a  = cur_r;
    add_b  = sm_stride_r;
    add_ci = 1'b0;
    unique case (state_r) inside
      S_CHK: begin
        add_a = hidden_base_r;
        add_b = delta;
      end
      S_LAST, S_OBASE: begin
        add_a = cb_r;
        add_b = mul_r[63:0];
      end
      S_END: begin
        add_a = acc_r;
        add_b = SM_REGION_SIZE;
      end
      S_REND: begin
        add_a = rbase_r;
        add_b = rbytes_r;
      end
      S_LOW: begin
        add_a  = rbase_r;
        add_b  = ~SM_REGION_SIZE;
        add_ci = 1'b1;
      end
      S_OADDR: begin
        add_a = acc_r;
        add_b = 64'(slot_r) * SLOT_STRIDE_BYTES;
      end
      default: begin
        add_a = cur_r;
        add_b = sm_stride_r;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {64'd0, add_ci};
  assign add_co  = add_sum[64];

  // shared multiplier: last region offset, or owner region offset
  assign mul_a   = (state_r == S_CHK) ? 10'(sm_total_r - 11'd1) : owner_r;
  assign mul_nxt = 74'(mul_a) * 74'(sm_stride_r);

  always_comb begin
    state_nxt  = state_r;
    cb_nxt     = cb_r;
    acc_nxt    = acc_r;
    rend_nxt   = rend_r;
    lo_nxt     = lo_r;
    lo_any_nxt = lo_any_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    st_nxt     = st_r;
    addr_nxt   = addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHK;
          st_nxt    = ST_OK;
          addr_nxt  = 64'd0;
        end
      end
      S_CHK: begin
        cb_nxt = add_sum[63:0];
        if (layout_bad) begin
          st_nxt    = ST_INVALID;
          state_nxt = S_OUT;
        end else if (color_bad) begin
          st_nxt    = ST_COLOR;
          state_nxt = S_OUT;
        end else if (add_co) begin
          st_nxt    = ST_OVERFLOW;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        acc_nxt = add_sum[63:0];
        if (add_co || (|mul_r[73:64])) begin
          st_nxt    = ST_OVERFLOW;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (add_co) begin
          st_nxt    = ST_OVERFLOW;
          state_nxt = S_OUT;
        end else if (func_r == FUNC_RANGE) begin
          state_nxt = S_REND;
        end else begin
          state_nxt = S_OMUL;
        end
      end
      S_REND: begin
        rend_nxt = add_sum[63:0];
        if (add_co || (rbytes_r == 64'd0)) begin
          st_nxt    = ST_INVALID;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LOW;
        end
      end
      S_LOW: begin
        // no carry out means range_base is below one region size
        lo_nxt     = add_sum[63:0];
        lo_any_nxt = !add_co;
        cur_nxt    = cb_r;
        idx_nxt    = 11'd0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r == sm_total_r) begin
          state_nxt = S_OUT;
        end else if (hit) begin
          st_nxt    = ST_COLLISION;
          state_nxt = S_OUT;
        end else if (past_end) begin
          state_nxt = S_OUT;
        end else begin
          cur_nxt = add_sum[63:0];
          idx_nxt = idx_r + 11'd1;
        end
      end
      S_OMUL: begin
        if ((11'(owner_r) >= sm_total_r) || (slot_r >= SLOTS_PER_SM)) begin
          st_nxt    = ST_INVALID;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_OBASE;
        end
      end
      S_OBASE: begin
        acc_nxt = add_sum[63:0];
        if (add_co || (|mul_r[73:64])) begin
          st_nxt    = ST_OVERFLOW;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_OADDR;
        end
      end
      S_OADDR: begin
        if (add_co || (|(add_sum[63:0] & ALIGN_MASK))) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          addr_nxt = add_sum[63:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      hidden_base_r <= 64'd0;
      base_color_r  <= 8'd0;
      line_bytes_r  <= 16'd128;
      sm_total_r    <= 11'd1;
      sm_stride_r   <= 64'd65536;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HIDDEN_BASE: hidden_base_r <= cfg_wdata;
          CFG_BASE_COLOR:  base_color_r  <= cfg_wdata[7:0];
          CFG_LINE_BYTES:  line_bytes_r  <= cfg_wdata[15:0];
          CFG_SM_TOTAL:    sm_total_r    <= cfg_wdata[10:0];
          CFG_SM_STRIDE:   sm_stride_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r   <= in_func;
      owner_r  <= in_owner_sm;
      slot_r   <= in_slot_index;
      rbase_r  <= in_range_base;
      rbytes_r <= in_range_bytes;
    end
    if (state_r == S_CHK || state_r == S_OMUL) begin
      mul_r <= mul_nxt;
    end
    cb_r     <= cb_nxt;
    acc_r    <= acc_nxt;
    rend_r   <= rend_nxt;
    lo_r     <= lo_nxt;
    lo_any_r <= lo_any_nxt;
    cur_r    <= cur_nxt;
    idx_r    <= idx_nxt;
    st_r     <= st_nxt;
    addr_r   <= addr_nxt;
    if (state_r == S_OUT && out_free) begin
      out_status_r  <= st_r;
      out_address_r <= addr_r;
    end
  end

  a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_CHK)
    else $error("accepted word did not start the layout check");

  a_error_has_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_address == 64'd0)
    else $error("error result carries an address");

  a_address_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_address & ALIGN_MASK) == 64'd0)
    else $error("result address misaligned");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= sm_total_r)
    else $error("scan index ran past the region count");

  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_COLLISION)
    else $error("undefined status code");

endmodule
